// File: hw/rtl/xor_decrypt_record_deframer_defines.svh
// Assertion macros shared by the deframer's checker.
`ifndef XOR_DECRYPT_RECORD_DEFRAMER_DEFINES_SVH
`define XOR_DECRYPT_RECORD_DEFRAMER_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define XDRD_ASSERT_SAME(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define XDRD_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: hw/rtl/xdrd_pkg.sv
// Types and constants shared by the XOR decrypting record deframer.
`default_nettype none

package xdrd_pkg;

  localparam int unsigned KEY_INDEX_W = 4;
  localparam int unsigned CFG_DATA_W  = 64;

  typedef logic [1:0] cfg_index_t;

  localparam cfg_index_t CFG_KEY_LOW  = 2'd0;
  localparam cfg_index_t CFG_KEY_HIGH = 2'd1;
  localparam cfg_index_t CFG_KEY_LEN  = 2'd2;

  typedef enum logic [1:0] {
    ROLE_HASH    = 2'd0,
    ROLE_LENGTH  = 2'd1,
    ROLE_PAYLOAD = 2'd2
  } role_t;

  typedef enum logic [1:0] {
    PH_HASH    = 2'd0,
    PH_LENGTH  = 2'd1,
    PH_PAYLOAD = 2'd2
  } phase_t;

  typedef struct packed {
    logic [7:0]  plain_byte;
    role_t       byte_role;
    logic [63:0] record_hash;
    logic [31:0] payload_length;
    logic        header_complete;
    logic        record_end;
    logic        truncated;
  } result_t;

endpackage

`default_nettype wire

// File: hw/rtl/xdrd_keystream.sv
// Key registers, effective key length and the rotating key index.
`default_nettype none

module xdrd_keystream #(
  parameter int unsigned MAX_KEY_BYTES = 16
) (
  input  wire logic                               clk,
  input  wire logic                               rst_n,
  input  wire logic                               cfg_write_en,
  input  wire xdrd_pkg::cfg_index_t               cfg_index,
  input  wire logic [xdrd_pkg::CFG_DATA_W-1:0]    cfg_data,
  input  wire logic                               advance,
  input  wire logic                               clear,
  output logic [7:0]                              key_byte
);
  import xdrd_pkg::*;

  localparam logic [4:0] MaxLen = 5'(MAX_KEY_BYTES);

  logic [63:0]            key_low_r;
  logic [63:0]            key_high_r;
  logic [4:0]             key_len_r;
  logic [KEY_INDEX_W-1:0] key_index_r;
  logic [KEY_INDEX_W-1:0] key_index_nxt;
  logic [127:0]           key_all;
  logic [4:0]             eff_len;
  logic [4:0]             next_idx;

  assign key_all  = {key_high_r, key_low_r};
  assign key_byte = key_all[{key_index_r, 3'b000} +: 8];

  // A length of zero behaves as one; anything above the maximum saturates.
  always_comb begin
    if (key_len_r == 5'd0) begin
      eff_len = 5'd1;
    end else if (key_len_r > MaxLen) begin
      eff_len = MaxLen;
    end else begin
      eff_len = key_len_r;
    end
  end

  assign next_idx      = {1'b0, key_index_r} + 5'd1;
  assign key_index_nxt = (next_idx >= eff_len) ? '0 : next_idx[KEY_INDEX_W-1:0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      key_low_r  <= '0;
      key_high_r <= '0;
      key_len_r  <= 5'd1;
    end else if (cfg_write_en) begin
      unique case (cfg_index)
        CFG_KEY_LOW:  key_low_r  <= cfg_data;
        CFG_KEY_HIGH: key_high_r <= cfg_data;
        CFG_KEY_LEN:  key_len_r  <= cfg_data[4:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      key_index_r <= '0;
    end else if (advance) begin
      key_index_r <= clear ? '0 : key_index_nxt;
    end
  end

endmodule

`default_nettype wire

// File: hw/rtl/xdrd_parser.sv
// Record header parser: hash and length assembly and payload countdown.
`default_nettype none

module xdrd_parser (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              advance,
  input  wire logic              end_of_stream,
  input  wire logic [7:0]        plain_byte,
  output xdrd_pkg::result_t      result
);
  import xdrd_pkg::*;

  phase_t      phase_r;
  phase_t      phase_nxt;
  logic [3:0]  count_r;
  logic [3:0]  count_nxt;
  logic [3:0]  count_inc;
  logic [63:0] hash_r;
  logic [63:0] hash_nxt;
  logic [63:0] hash_base;
  logic [31:0] len_r;
  logic [31:0] len_nxt;
  logic [31:0] remain_r;
  logic [31:0] remain_nxt;
  role_t       role;
  logic        hdr_done;
  logic        rec_end;

  assign count_inc = count_r + 4'd1;
  // The first hash byte of a record starts both accumulators afresh.
  assign hash_base = (count_r == 4'd0) ? '0 : hash_r;

  always_comb begin
    phase_nxt  = phase_r;
    count_nxt  = count_r;
    hash_nxt   = hash_r;
    len_nxt    = len_r;
    remain_nxt = remain_r;
    role       = ROLE_HASH;
    hdr_done   = 1'b0;
    rec_end    = 1'b0;
    unique case (phase_r)
      PH_LENGTH: begin
        role      = ROLE_LENGTH;
        len_nxt   = len_r | (32'(plain_byte) << {count_r[1:0], 3'b000});
        count_nxt = count_inc;
        if (count_inc >= 4'd4) begin
          count_nxt = '0;
          hdr_done  = 1'b1;
          if (len_nxt == 32'd0) begin
            rec_end   = 1'b1;
            phase_nxt = PH_HASH;
          end else begin
            remain_nxt = len_nxt;
            phase_nxt  = PH_PAYLOAD;
          end
        end
      end
      PH_PAYLOAD: begin
        role       = ROLE_PAYLOAD;
        remain_nxt = remain_r - 32'd1;
        if (remain_nxt == 32'd0) begin
          rec_end   = 1'b1;
          phase_nxt = PH_HASH;
        end
      end
      default: begin
        // The unused phase code behaves as the hash phase.
        role      = ROLE_HASH;
        phase_nxt = PH_HASH;
        len_nxt   = (count_r == 4'd0) ? '0 : len_r;
        hash_nxt  = hash_base | (64'(plain_byte) << {count_r[2:0], 3'b000});
        count_nxt = count_inc;
        if (count_inc >= 4'd8) begin
          count_nxt = '0;
          phase_nxt = PH_LENGTH;
        end
      end
    endcase
  end

  always_comb begin
    result.plain_byte      = plain_byte;
    result.byte_role       = role;
    result.record_hash     = hash_nxt;
    result.payload_length  = len_nxt;
    result.header_complete = hdr_done;
    result.record_end      = rec_end;
    result.truncated       = end_of_stream & ~rec_end;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r  <= PH_HASH;
      count_r  <= '0;
      hash_r   <= '0;
      len_r    <= '0;
      remain_r <= '0;
    end else if (advance) begin
      if (end_of_stream) begin
        phase_r  <= PH_HASH;
        count_r  <= '0;
        hash_r   <= '0;
        len_r    <= '0;
        remain_r <= '0;
      end else begin
        phase_r  <= phase_nxt;
        count_r  <= count_nxt;
        hash_r   <= hash_nxt;
        len_r    <= len_nxt;
        remain_r <= remain_nxt;
      end
    end
  end

endmodule

`default_nettype wire

// File: hw/rtl/xdrd_outreg.sv
// Result register with its valid flag and the input-side stall.
`default_nettype none

module xdrd_outreg (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              item_valid,
  output logic                   item_stall,
  input  wire xdrd_pkg::result_t result_in,
  output logic                   out_valid,
  input  wire logic              out_stall,
  output xdrd_pkg::result_t      result_out
);
  import xdrd_pkg::*;

  logic    valid_r;
  logic    valid_nxt;
  logic    load;
  result_t result_r;

  // A new item may enter when the register is empty or when the held result leaves in the same cycle.
  assign item_stall = valid_r & out_stall;
  assign load       = item_valid & ~item_stall;
  assign valid_nxt  = load | (valid_r & out_stall);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      result_r <= result_in;
    end
  end

  assign out_valid  = valid_r;
  assign result_out = result_r;

endmodule

`default_nettype wire

// File: hw/rtl/xor_decrypt_record_deframer.sv
// Top level of the repeating-key XOR decryptor and record deframer.
//
// Input channel: one cipher byte per item, with an end-of-stream mark on
// the last byte of a stream. Result channel: one result per input item,
// carrying the plain byte, its role in the record and the header fields.
// The configuration port writes the two key words and the key length; it
// is only to be written while the block is idle.
// An accepted item's result is registered and shown in the cycle after
// its acceptance. Throughput is one item per cycle, set by the
// single result register that sits after the key XOR and header parser.
// When the receiver stalls, the result register holds its item and the
// input stalls only while that register is full and stalled.
// Reset clears the key to zero, the key length to one, the key index and
// every parser state; no clearing pass follows, items are taken at once.
// After an end-of-stream item the key index and parser restart.
`default_nettype none

module xor_decrypt_record_deframer #(
  parameter int unsigned MAX_KEY_BYTES = 16
) (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  input  wire logic                            in_valid,
  output logic                                 in_stall,
  input  wire logic [7:0]                      in_cipher_byte,
  input  wire logic                            in_end_of_stream,
  output logic                                 out_valid,
  input  wire logic                            out_stall,
  output logic [7:0]                           out_plain_byte,
  output logic [1:0]                           out_byte_role,
  output logic [63:0]                          out_record_hash,
  output logic [31:0]                          out_payload_length,
  output logic                                 out_header_complete,
  output logic                                 out_record_end,
  output logic                                 out_truncated,
  input  wire logic                            cfg_write_en,
  input  wire xdrd_pkg::cfg_index_t            cfg_index,
  input  wire logic [xdrd_pkg::CFG_DATA_W-1:0] cfg_data
);
  import xdrd_pkg::*;

  logic       in_accept;
  logic [7:0] key_byte;
  logic [7:0] plain_byte;
  result_t    result;
  result_t    result_q;

  assign in_accept  = in_valid & ~in_stall;
  assign plain_byte = in_cipher_byte ^ key_byte;

  xdrd_keystream #(
    .MAX_KEY_BYTES(MAX_KEY_BYTES)
  ) u_keystream (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_write_en(cfg_write_en),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .advance     (in_accept),
    .clear       (in_end_of_stream),
    .key_byte    (key_byte)
  );

  xdrd_parser u_parser (
    .clk          (clk),
    .rst_n        (rst_n),
    .advance      (in_accept),
    .end_of_stream(in_end_of_stream),
    .plain_byte   (plain_byte),
    .result       (result)
  );

  xdrd_outreg u_outreg (
    .clk       (clk),
    .rst_n     (rst_n),
    .item_valid(in_valid),
    .item_stall(in_stall),
    .result_in (result),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .result_out(result_q)
  );

  assign out_plain_byte      = result_q.plain_byte;
  assign out_byte_role       = result_q.byte_role;
  assign out_record_hash     = result_q.record_hash;
  assign out_payload_length  = result_q.payload_length;
  assign out_header_complete = result_q.header_complete;
  assign out_record_end      = result_q.record_end;
  assign out_truncated       = result_q.truncated;

endmodule

`default_nettype wire

// File: hw/rtl/xdrd_checker.sv
// Port-level checker for the deframer and the bind that attaches it.
`default_nettype none

`include "xor_decrypt_record_deframer_defines.svh"

module xdrd_checker (
  input wire logic        clk,
  input wire logic        rst_n,
  input wire logic        in_valid,
  input wire logic        in_stall,
  input wire logic        out_valid,
  input wire logic        out_stall,
  input wire logic [7:0]  out_plain_byte,
  input wire logic [1:0]  out_byte_role,
  input wire logic [31:0] out_payload_length,
  input wire logic        out_header_complete,
  input wire logic        out_record_end,
  input wire logic        out_truncated
);
  import xdrd_pkg::*;

  `XDRD_ASSERT_NEXT(a_result_follows, clk, rst_n, in_valid && !in_stall, out_valid, "accepted item gave no result in the next cycle")
  `XDRD_ASSERT_NEXT(a_stalled_holds, clk, rst_n, out_valid && out_stall, out_valid && $stable(out_plain_byte), "stalled result changed or vanished")
  `XDRD_ASSERT_SAME(a_header_role, clk, rst_n, out_valid && out_header_complete, out_byte_role == ROLE_LENGTH, "header complete on a byte that is not a length byte")
  `XDRD_ASSERT_SAME(a_end_role, clk, rst_n, out_valid && out_record_end, out_byte_role == ROLE_PAYLOAD || (out_header_complete && out_payload_length == 32'd0), "record end on a byte that cannot close a record")
  `XDRD_ASSERT_SAME(a_trunc_excl, clk, rst_n, out_valid && out_truncated, !out_record_end, "truncated flag on a byte that ends a record")

endmodule

bind xor_decrypt_record_deframer xdrd_checker u_xdrd_checker (.*);

`default_nettype wire
